// ----- sv/efp_pkg.sv -----
package efp_pkg;

  localparam int COORD_W = 32;
  localparam int INDEX_W = 12;
  localparam int COUNT_W = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int Q_FRAC = 28;
  localparam int Q_FRAC_HALF = 27;
  localparam int WIDE_W = 66;

  localparam int COLUMN_LIMIT_DEF = 4096;
  localparam int ROW_LIMIT_DEF = 4096;

  localparam logic [CFG_ADDR_W-1:0] CFG_REAL_ORIGIN = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_REAL_STEP = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_IMAG_ORIGIN = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_IMAG_STEP = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ITER_LIMIT = 3'd4;

  localparam logic signed [COORD_W-1:0] REAL_ORIGIN_RST = -32'sd536870912;
  localparam logic signed [COORD_W-1:0] REAL_STEP_RST = 32'sd419649;
  localparam logic signed [COORD_W-1:0] IMAG_ORIGIN_RST = -32'sd268435456;
  localparam logic signed [COORD_W-1:0] IMAG_STEP_RST = 32'sd497563;
  localparam logic [COUNT_W-1:0] ITER_LIMIT_RST = 16'd500;

  // Escape bound: |z|^2 > 4 in Q8.56.
  localparam logic [64:0] ESC_BOUND = 65'h1 << (2 * Q_FRAC + 2);

  localparam logic signed [WIDE_W-1:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [WIDE_W-1:0] SAT_MIN = -66'sd2147483648;

  typedef struct packed {
    logic [INDEX_W-1:0] column;
    logic [INDEX_W-1:0] row;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] out_column;
    logic [INDEX_W-1:0] out_row;
    logic [COUNT_W-1:0] iteration_count;
    logic               escaped;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic coord_mul;
    logic coord_add;
    logic iter_mul;
    logic iter_step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic escape;
    logic at_limit;
  } dp_status_t;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[COORD_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/efp_ctrl.sv -----
module efp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  efp_pkg::dp_status_t   status,
  output efp_pkg::ctrl_cmd_t    cmd
);
  import efp_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CMUL = 3'd1;
  localparam logic [2:0] ST_CADD = 3'd2;
  localparam logic [2:0] ST_IMUL = 3'd3;
  localparam logic [2:0] ST_IUPD = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = ST_CMUL;
        end
      end
      ST_CMUL: begin
        cmd.coord_mul = 1'b1;
        state_nxt = ST_CADD;
      end
      ST_CADD: begin
        cmd.coord_add = 1'b1;
        state_nxt = ST_IMUL;
      end
      ST_IMUL: begin
        cmd.iter_mul = 1'b1;
        state_nxt = ST_IUPD;
      end
      ST_IUPD: begin
        // Escape or the limit ends the pixel; on a tie the result reports an escape.
        if (status.escape || status.at_limit) begin
          cmd.finish = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cmd.iter_step = 1'b1;
          state_nxt = ST_IMUL;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- sv/efp_datapath.sv -----
module efp_datapath #(
  parameter int COLUMN_LIMIT = efp_pkg::COLUMN_LIMIT_DEF,
  parameter int ROW_LIMIT = efp_pkg::ROW_LIMIT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [efp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [efp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  efp_pkg::in_item_t                   in_data,
  input  efp_pkg::ctrl_cmd_t                  cmd,
  output efp_pkg::dp_status_t                 status,
  output logic                                out_valid,
  output efp_pkg::out_item_t                  out_data
);
  import efp_pkg::*;

  localparam logic [16:0] COL_LIM = 17'(COLUMN_LIMIT);
  localparam logic [16:0] ROW_LIM = 17'(ROW_LIMIT);

  logic signed [COORD_W-1:0] real_origin_r;
  logic signed [COORD_W-1:0] real_step_r;
  logic signed [COORD_W-1:0] imag_origin_r;
  logic signed [COORD_W-1:0] imag_step_r;
  logic [COUNT_W-1:0]        iter_limit_r;

  logic [INDEX_W-1:0] col_r;
  logic [INDEX_W-1:0] row_r;
  logic signed [44:0] re_prod_r;
  logic signed [44:0] im_prod_r;
  logic signed [COORD_W-1:0] c_re_r;
  logic signed [COORD_W-1:0] c_im_r;
  logic signed [COORD_W-1:0] x_r;
  logic signed [COORD_W-1:0] y_r;
  logic signed [63:0] xx_r;
  logic signed [63:0] yy_r;
  logic signed [63:0] xy_r;
  logic [COUNT_W-1:0] count_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic [INDEX_W-1:0] col_idx;
  logic [INDEX_W-1:0] row_idx;
  logic signed [WIDE_W-1:0] re_sum;
  logic signed [WIDE_W-1:0] im_sum;
  logic signed [WIDE_W-1:0] diff;
  logic signed [WIDE_W-1:0] nx_sum;
  logic signed [WIDE_W-1:0] ny_sum;
  logic [64:0] mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      real_origin_r <= REAL_ORIGIN_RST;
      real_step_r   <= REAL_STEP_RST;
      imag_origin_r <= IMAG_ORIGIN_RST;
      imag_step_r   <= IMAG_STEP_RST;
      iter_limit_r  <= ITER_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_REAL_ORIGIN: real_origin_r <= $signed(cfg_wdata);
        CFG_REAL_STEP:   real_step_r   <= $signed(cfg_wdata);
        CFG_IMAG_ORIGIN: imag_origin_r <= $signed(cfg_wdata);
        CFG_IMAG_STEP:   imag_step_r   <= $signed(cfg_wdata);
        CFG_ITER_LIMIT:  iter_limit_r  <= cfg_wdata[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Indices past the configured image size clamp to its last column or row.
  assign col_idx = ({5'd0, col_r} >= COL_LIM) ? INDEX_W'(COLUMN_LIMIT - 1) : col_r;
  assign row_idx = ({5'd0, row_r} >= ROW_LIM) ? INDEX_W'(ROW_LIMIT - 1) : row_r;

  assign re_sum = WIDE_W'(re_prod_r) + WIDE_W'(real_origin_r);
  assign im_sum = WIDE_W'(im_prod_r) + WIDE_W'(imag_origin_r);

  assign diff   = WIDE_W'(xx_r) - WIDE_W'(yy_r);
  assign nx_sum = (diff >>> Q_FRAC) + WIDE_W'(c_re_r);
  assign ny_sum = (WIDE_W'(xy_r) >>> Q_FRAC_HALF) + WIDE_W'(c_im_r);

  // Squares are never negative, so the top bit is clear.
  assign mag = {1'b0, xx_r} + {1'b0, yy_r};

  assign status.escape   = (mag > ESC_BOUND);
  assign status.at_limit = (count_r == iter_limit_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r <= in_data.column;
      row_r <= in_data.row;
    end
    if (cmd.coord_mul) begin
      re_prod_r <= $signed({1'b0, col_idx}) * real_step_r;
      im_prod_r <= $signed({1'b0, row_idx}) * imag_step_r;
    end
    if (cmd.coord_add) begin
      c_re_r  <= sat32(re_sum);
      c_im_r  <= sat32(im_sum);
      x_r     <= '0;
      y_r     <= '0;
      count_r <= '0;
    end
    if (cmd.iter_mul) begin
      xx_r <= x_r * x_r;
      yy_r <= y_r * y_r;
      xy_r <= x_r * y_r;
    end
    if (cmd.iter_step) begin
      x_r     <= sat32(nx_sum);
      y_r     <= sat32(ny_sum);
      count_r <= count_r + 1'b1;
    end
    if (cmd.finish) begin
      out_r.out_column      <= col_r;
      out_r.out_row         <= row_r;
      out_r.iteration_count <= count_r;
      out_r.escaped         <= status.escape;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- sv/escape_time_fractal_pixel.sv -----
// Channel  | Ports                              | Beat taken when
// ---------+------------------------------------+-------------------------------
// input    | start, busy, in_data               | start high and busy low
// result   | out_valid, out_data                | every cycle out_valid is high
// config   | cfg_we, cfg_addr, cfg_wdata        | every cycle cfg_we is high
//
// From its accepted beat, a pixel first forms the point in a coordinate multiply and a
// coordinate add, then each pass of the iteration loop runs the three squaring
// multipliers and then the update and escape compare, until the result is strobed.
// Busy falls in the cycle the result is strobed, so the next pixel may be started then.
// Reset is synchronous and active low; it restores the register defaults.
// Results are strobed for one cycle and cannot be held off by the receiver.
module escape_time_fractal_pixel #(
  parameter int COLUMN_LIMIT = efp_pkg::COLUMN_LIMIT_DEF,
  parameter int ROW_LIMIT = efp_pkg::ROW_LIMIT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  efp_pkg::in_item_t               in_data,
  output logic                            out_valid,
  output efp_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [efp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [efp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import efp_pkg::*;

  // The controller sequences one pixel at a time; the datapath holds the
  // configuration registers, the iterate and the result register.
  ctrl_cmd_t  cmd;
  dp_status_t status;

  efp_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  efp_datapath #(
    .COLUMN_LIMIT (COLUMN_LIMIT),
    .ROW_LIMIT    (ROW_LIMIT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
